>>> src/multichannel_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average block
// Both macros sample on the rising clock edge and are off while reset is low.
// Setting NO_ASSERTIONS turns every use into empty text.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Full property as written.
`define MMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define MMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) else $error(msg);

`else

`define MMA_ASSERT(lbl, clk, rst, prop, msg)
`define MMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Defaults for the top level parameters
  localparam int CHANNELS_DEF    = 8;
  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 12;

  // Fixed field widths of the transactions
  localparam int CHAN_W  = 3;
  localparam int FIELD_W = 12;

  // Output queue; depth is a power of two so the pointers wrap naturally
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [CHAN_W-1:0]  channel;
    logic [FIELD_W-1:0] sample;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] smoothed;
    logic [FIELD_W-1:0] raw;
  } out_item_t;

  // Control travelling with a finished running sum
  typedef struct packed {
    logic valid;   // stage holds a transaction
    logic ok;      // channel index is in range
  } stage_ctl_t;

endpackage

>>> src/mma_stream_if.sv
// ----------------------------------------------------------------------------
// mma_in_if / mma_out_if
// Valid/ready channels carrying the input and result transactions.
// ----------------------------------------------------------------------------
interface mma_in_if;
  import mma_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mma_out_if;
  import mma_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

>>> src/mma_core.sv
// ----------------------------------------------------------------------------
// mma_core
// Ring position, history lookup and running sum update per transaction.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_assert.svh"

module mma_core #(
  parameter int CHANNELS    = 8,
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    acc_i,
  input  mma_pkg::in_item_t                       item_i,
  output mma_pkg::stage_ctl_t                     ctl_o,
  output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]   sum_o,
  output logic [SAMPLE_BITS-1:0]                  raw_o,
  output logic [1:0]                              inflight_o
);
  import mma_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + POS_W;
  localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(WINDOW / 2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  // Accept side
  logic                   in_ok;
  logic [CH_W-1:0]        in_ch;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] in_smp;
  logic                   in_wr;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  // Lookup stage
  logic                   s1_v_r;
  logic                   s1_wr_r;
  logic                   s1_ok_r;
  logic [CH_W-1:0]        s1_ch_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [SAMPLE_BITS-1:0] s1_smp_r;
  logic                   fwd_r, fwd_nxt;
  logic [SAMPLE_BITS-1:0] fwd_data_r;
  logic [SAMPLE_BITS-1:0] ram_q;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SUM_W-1:0]       sum_cur;
  logic [SUM_W-1:0]       sum_new;
  logic                   s1_we;

  // Per-channel state and history valid bits
  logic [SUM_W-1:0]       sum_r [CHANNELS];
  logic [SAMPLE_BITS-1:0] raw_r [CHANNELS];
  logic [DEPTH-1:0]       hist_vld_r;

  // Sum stage
  stage_ctl_t             s2_ctl_r;
  logic [SUM_W-1:0]       s2_sum_r;
  logic [SAMPLE_BITS-1:0] s2_raw_r;

  assign in_ok   = 32'(item_i.channel) < 32'(CHANNELS);
  assign in_ch   = in_ok ? CH_W'(item_i.channel) : '0;
  assign rd_addr = ADDR_W'(ADDR_W'(in_ch) * ADDR_W'(WINDOW)) + ADDR_W'(pos_r);
  assign in_smp  = SAMPLE_BITS'(item_i.sample);
  assign in_wr   = (item_i.command == CMD_SAMPLE) && in_ok;

  always_comb begin
    pos_nxt = pos_r;
    if (acc_i && (item_i.command == CMD_SAMPLE) && item_i.frame_end) begin
      pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
    end
  end

  // The entry being written this edge is read by the next transaction at
  // the same edge; the RAM returns old data, so bypass it.
  assign fwd_nxt = s1_v_r && s1_wr_r && (s1_addr_r == rd_addr);

  mma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk     (clk),
    .we_i    (s1_we),
    .waddr_i (s1_addr_r),
    .wdata_i (s1_smp_r),
    .raddr_i (rd_addr),
    .rdata_o (ram_q)
  );

  assign s1_we   = s1_v_r && s1_wr_r;
  assign old_smp = fwd_r ? fwd_data_r : (hist_vld_r[s1_addr_r] ? ram_q : '0);
  assign sum_cur = sum_r[s1_ch_r];
  assign sum_new = sum_cur - SUM_W'(old_smp) + SUM_W'(s1_smp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_v_r     <= 1'b0;
      s2_ctl_r   <= '0;
      hist_vld_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= SUM_INIT;
        raw_r[i] <= '0;
      end
    end else begin
      pos_r          <= pos_nxt;
      s1_v_r         <= acc_i;
      s2_ctl_r.valid <= s1_v_r;
      s2_ctl_r.ok    <= s1_ok_r;
      if (s1_we) begin
        hist_vld_r[s1_addr_r] <= 1'b1;
        sum_r[s1_ch_r]        <= sum_new;
        raw_r[s1_ch_r]        <= s1_smp_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_wr_r    <= in_wr;
    s1_ok_r    <= in_ok;
    s1_ch_r    <= in_ch;
    s1_addr_r  <= rd_addr;
    s1_smp_r   <= in_smp;
    fwd_r      <= fwd_nxt;
    fwd_data_r <= s1_smp_r;
    s2_sum_r   <= s1_wr_r ? sum_new : sum_cur;
    s2_raw_r   <= s1_wr_r ? s1_smp_r : raw_r[s1_ch_r];
  end

  assign ctl_o      = s2_ctl_r;
  assign sum_o      = s2_sum_r;
  assign raw_o      = s2_raw_r;
  assign inflight_o = {1'b0, s1_v_r} + {1'b0, s2_ctl_r.valid};

  `MMA_ASSERT(a_pos_range, clk, rst_n, pos_r <= POS_LAST, "ring position out of window")
  `MMA_ASSERT_NEXT(a_hist_marked, clk, rst_n, s1_we, hist_vld_r[$past(s1_addr_r)],
    "history entry not marked after write")

endmodule

>>> src/mma_div.sv
// ----------------------------------------------------------------------------
// mma_div
// Divides the running sum by the window length with a reciprocal multiply.
// ----------------------------------------------------------------------------
module mma_div #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  mma_pkg::stage_ctl_t                   ctl_i,
  input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0] sum_i,
  input  logic [SAMPLE_BITS-1:0]                raw_i,
  output logic                                  push_o,
  output mma_pkg::out_item_t                    res_o
);
  import mma_pkg::*;

  localparam int POS_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_BITS + POS_W;
  localparam int SH    = SUM_W + POS_W;
  localparam int M_W   = SUM_W + 1;
  // ceil(2^SH / WINDOW): exact floor division for every SUM_W-bit dividend
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic [2*M_W-1:0]       prod;
  logic [SAMPLE_BITS-1:0] quot;

  assign prod = {{(M_W){1'b0}}, 1'b0, sum_i} * {{(M_W){1'b0}}, M_W'(RECIP)};
  assign quot = prod[SH +: SAMPLE_BITS];

  assign push_o         = ctl_i.valid;
  assign res_o.smoothed = ctl_i.ok ? FIELD_W'(quot) : '0;
  assign res_o.raw      = ctl_i.ok ? FIELD_W'(raw_i) : '0;

endmodule

>>> src/mma_oq.sv
// ----------------------------------------------------------------------------
// mma_oq
// Small result queue that decouples the pipeline from output backpressure.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_assert.svh"

module mma_oq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_i,
  input  mma_pkg::out_item_t          data_i,
  mma_out_if.source                   out_m,
  output logic [mma_pkg::OQ_CNT_W-1:0] count_o
);
  import mma_pkg::*;

  out_item_t             mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   head_r, tail_r;
  logic [OQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  pop;

  assign pop       = out_m.valid && out_m.ready;
  assign count_nxt = count_r + OQ_CNT_W'(push_i) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_i) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[tail_r] <= data_i;
    end
  end

  assign out_m.valid = (count_r != '0);
  assign out_m.data  = mem_r[head_r];
  assign count_o     = count_r;

  `MMA_ASSERT(a_no_overflow, clk, rst_n, push_i |-> (count_r < OQ_DEPTH) || pop,
    "result pushed into full queue")

endmodule

>>> src/multichannel_moving_average.sv
// Each transaction passes the RAM read and the sum update before its result is queued.
// One transaction per cycle while in_s.ready is high; each input gives exactly one result.
// Result queue of 4 entries; input stalls only when queued plus in-flight results fill it.
// Reset (rst_n, synchronous, active low): history reads as zero, sums at WINDOW/2,
// raw values zero, ring position zero; ready once reset is released, no clearing pass.
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel box-car moving average of ADC samples over WINDOW samples.
// ----------------------------------------------------------------------------
`include "multichannel_moving_average_assert.svh"

module multichannel_moving_average #(
  parameter int CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int WINDOW      = mma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_s,
  mma_out_if.source  out_m
);
  import mma_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

  // Pipeline overview:
  //   accept edge : input registered, history RAM read at channel*WINDOW
  //                 + ring position, ring position advanced on a frame_end sample
  //   sum stage   : old sample swapped out (bypassed when the previous
  //                 transaction wrote the same entry), running sum and
  //                 last raw value updated for an in-range sample
  //   queue stage : sum / WINDOW by reciprocal multiply, result queued
  // The core never stalls; input ready is a credit check that keeps room
  // in the queue for every transaction still in the pipeline.

  logic                   in_rdy;
  logic                   in_acc;
  stage_ctl_t             s2_ctl;
  logic [SUM_W-1:0]       s2_sum;
  logic [SAMPLE_BITS-1:0] s2_raw;
  logic [1:0]             inflight;
  logic                   q_push;
  out_item_t              q_data;
  logic [OQ_CNT_W-1:0]    q_count;

  // Queue entries plus transactions in flight must leave one free slot;
  // nothing is taken while reset is held
  assign in_rdy     = rst_n && ((q_count + OQ_CNT_W'(inflight)) < OQ_CNT_W'(OQ_DEPTH));
  assign in_s.ready = in_rdy;
  assign in_acc     = in_s.valid && in_rdy;

  mma_core #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (in_acc),
    .item_i     (in_s.data),
    .ctl_o      (s2_ctl),
    .sum_o      (s2_sum),
    .raw_o      (s2_raw),
    .inflight_o (inflight)
  );

  // Rounded average; out-of-range channels give zero fields
  mma_div #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .ctl_i  (s2_ctl),
    .sum_i  (s2_sum),
    .raw_i  (s2_raw),
    .push_o (q_push),
    .res_o  (q_data)
  );

  mma_oq u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_data),
    .out_m   (out_m),
    .count_o (q_count)
  );

  // Every accepted transaction reaches the queue after the lookup and sum stages
  `MMA_ASSERT(a_fixed_latency, clk, rst_n, in_acc |-> ##2 q_push,
    "accepted transaction did not reach result queue")
  // Credit accounting never promises more than the queue holds
  `MMA_ASSERT(a_credit, clk, rst_n, (q_count + OQ_CNT_W'(inflight)) <= OQ_CNT_W'(OQ_DEPTH),
    "queue credit exceeded")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the multichannel moving average against a cycle-free box-car
// predictor. Each input transaction is turned into its expected average and
// raw value when it is accepted. Results are compared field by field in
// arrival order. The sender runs in bursts with random gaps, and the receiver
// stalls on a pattern of its own with long hold-offs at times.
// ----------------------------------------------------------------------------
module tb;
  import mma_pkg::*;

  localparam int CH       = CHANNELS_DEF;
  localparam int WIN      = WINDOW_DEF;
  localparam int SMP_BITS = SAMPLE_BITS_DEF;
  localparam int SUM_W    = 16;
  localparam int N_ITEMS  = 1850;
  localparam int MAX_CYC  = 400000;
  localparam int TAIL_CYC = 10;
  localparam int MAX_SHOW = 10;

  localparam logic [FIELD_W-1:0] SMP_MASK = FIELD_W'((1 << SMP_BITS) - 1);

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_MOSTLY,
    RX_PERIODIC
  } rx_mode_t;

  // One pending transaction; drain_first holds it back until all
  // earlier results have been checked.
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } stim_entry_t;

  logic clk;
  logic rst_n;

  mma_in_if  in_if ();
  mma_out_if out_if ();

  multichannel_moving_average i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  // --------------------------------------------------------------------------
  // Predictor state: per-channel history ring, running sums (with the
  // rounding offset folded in), last raw values and the shared ring slot.
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] hist_mem [CH][WIN];
  logic [SUM_W-1:0]   chan_sum [CH];
  logic [FIELD_W-1:0] chan_raw [CH];
  int                 ring_pos;

  stim_entry_t stim_q[$];
  out_item_t   avg_expected_q[$];

  int err_cnt;
  int n_accepted;     // updated nonblocking by the driver
  int n_checked;      // updated nonblocking by the monitor
  int cyc_cnt;
  bit rx_hold;        // long receiver hold-off, driven by its own process

  // Stimulus generation helpers
  bit                 drain_next;
  logic [FIELD_W-1:0] level [CH];

  // --------------------------------------------------------------------------
  // Box-car update: applies one transaction to the predictor state and
  // returns the addressed channel's average and raw value, zero if out of range.
  // --------------------------------------------------------------------------
  function automatic out_item_t boxcar_update(in_item_t it);
    out_item_t          res;
    logic [FIELD_W-1:0] smp;
    int                 ch;
    bit                 in_range;
    smp      = it.sample & SMP_MASK;
    ch       = int'(it.channel);
    in_range = ch < CH;
    if (it.command == CMD_SAMPLE) begin
      if (in_range) begin
        chan_sum[ch] = chan_sum[ch] - SUM_W'(hist_mem[ch][ring_pos]) + SUM_W'(smp);
        hist_mem[ch][ring_pos] = smp;
        chan_raw[ch] = smp;
      end
      // frame_end moves the shared slot even for an unused channel index
      if (it.frame_end)
        ring_pos = (ring_pos + 1) % WIN;
    end
    if (in_range) begin
      res.smoothed = FIELD_W'(chan_sum[ch] / WIN);
      res.raw      = chan_raw[ch];
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic void note_error(string what, int want, int got);
    err_cnt++;
    if (err_cnt <= MAX_SHOW)
      $display("ERROR @%0t: %s expected 0x%03h got 0x%03h", $realtime, what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void add_item(cmd_t cmd, int ch, int smp, bit fe);
    stim_entry_t e;
    e.item.command   = cmd;
    e.item.channel   = CHAN_W'(ch);
    e.item.sample    = FIELD_W'(smp);
    e.item.frame_end = fe;
    e.drain_first    = drain_next;
    drain_next       = 1'b0;
    stim_q.push_back(e);
  endfunction

  // Mix of extremes, full-range noise and a slowly drifting level per channel
  function automatic int pick_sample(int ch);
    int sel;
    int v;
    sel = $urandom_range(0, 7);
    case (sel)
      0: v = 0;
      1: v = (1 << FIELD_W) - 1;
      2, 3: v = $urandom_range(0, (1 << FIELD_W) - 1);
      default: begin
        v = int'(level[ch]) + $urandom_range(0, 128) - 64;
        if (v < 0) v = 0;
        if (v > (1 << FIELD_W) - 1) v = (1 << FIELD_W) - 1;
      end
    endcase
    level[ch] = FIELD_W'(v);
    return v;
  endfunction

  function automatic cmd_t rand_cmd();
    return $urandom_range(0, 1) ? CMD_READ : CMD_SAMPLE;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and known input values from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predictor starts in the reset state of the block
  initial begin
    for (int c = 0; c < CH; c++) begin
      for (int w = 0; w < WIN; w++)
        hist_mem[c][w] = '0;
      chan_sum[c] = SUM_W'(WIN / 2);
      chan_raw[c] = '0;
    end
    ring_pos = 0;
  end

  // --------------------------------------------------------------------------
  // Driver: offers the next pending transaction in bursts separated by
  // random gaps. The predictor runs here, at the edge of acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    stim_entry_t nxt;
    bit          took;
    int          burst_left;
    int          gap_left;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      took = in_if.valid && in_if.ready;
      if (took) begin
        avg_expected_q.push_back(boxcar_update(in_if.data));
        n_accepted <= n_accepted + 1;
      end
      if (!in_if.valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (stim_q[0].drain_first && (took || n_accepted != n_checked)) begin
          // pause until every earlier result has come out
          in_if.valid <= 1'b0;
        end else begin
          nxt = stim_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.data  <= nxt.item;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a quarter of the bursts are long and back to back
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(60, 150);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(0, 8);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here in cycles. It lasts well past the
  // depth of the result queue, so the block must stall its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : hold_proc
    int hold_timer;
    int hold_left;
    if (!rst_n) begin
      hold_timer = 300;
      hold_left  = 0;
      rx_hold    <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_timer > 0) begin
        hold_timer--;
      end else begin
        hold_left  = $urandom_range(60, 120);
        hold_timer = $urandom_range(1500, 2500);
      end
      rx_hold <= (hold_left > 0);
    end
  end

  // Receiver ready pattern, switching mode when its mode counter runs out
  always @(posedge clk) begin : ready_proc
    rx_mode_t rx_mode;
    int       mode_left;
    bit       pat;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode      = RX_ALWAYS;
      mode_left    = 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS:   pat = 1'b1;
        RX_HALF:     pat = 1'($urandom_range(0, 1));
        RX_MOSTLY:   pat = ($urandom_range(0, 7) != 0);
        RX_PERIODIC: pat = ((mode_left % 3) != 0);
        default:     pat = 1'b1;
      endcase
      out_if.ready <= pat && !rx_hold;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_checked <= n_checked + 1;
      if (avg_expected_q.size() == 0) begin
        note_error("unexpected result, smoothed", 0, int'(out_if.data.smoothed));
      end else begin
        want = avg_expected_q.pop_front();
        if (out_if.data.smoothed !== want.smoothed)
          note_error("smoothed", int'(want.smoothed), int'(out_if.data.smoothed));
        if (out_if.data.raw !== want.raw)
          note_error("raw", int'(want.raw), int'(out_if.data.raw));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog_proc
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > MAX_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int kind;
    int len;
    err_cnt    = 0;
    n_accepted = 0;
    n_checked  = 0;
    cyc_cnt    = 0;
    drain_next = 1'b0;
    for (int c = 0; c < CH; c++)
      level[c] = FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1));

    // Directed: reads straight after reset (frame_end on a read must not
    // move the ring), a full window of maximum samples on the top channel,
    // then repeated writes into one slot and a zero replacing a maximum.
    add_item(CMD_READ,   0,      0,     1'b1);
    add_item(CMD_READ,   CH - 1, 12'hFFF, 1'b0);
    for (int i = 0; i < WIN; i++)
      add_item(CMD_SAMPLE, CH - 1, 12'hFFF, 1'b1);
    add_item(CMD_READ,   CH - 1, 0,       1'b1);
    add_item(CMD_SAMPLE, 0,      0,       1'b0);
    add_item(CMD_SAMPLE, 0,      12'hAAA, 1'b0);
    add_item(CMD_SAMPLE, 0,      12'h555, 1'b1);
    add_item(CMD_READ,   3,      12'h5A5, 1'b0);
    add_item(CMD_SAMPLE, CH - 1, 0,       1'b0);
    add_item(CMD_READ,   CH - 1, 0,       1'b0);

    // Random: mostly well-formed conversion frames, some noise and
    // frames that break off or end early.
    drain_next = 1'b1;
    while (stim_q.size() < N_ITEMS) begin
      if (stim_q.size() > N_ITEMS / 2 && stim_q.size() < N_ITEMS / 2 + 10)
        drain_next = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        for (int c = 0; c < CH; c++) begin
          if ($urandom_range(0, 3) == 0)
            add_item(CMD_READ, $urandom_range(0, CH - 1),
                     $urandom_range(0, (1 << FIELD_W) - 1), 1'($urandom_range(0, 1)));
          add_item(CMD_SAMPLE, c, pick_sample(c), c == CH - 1);
        end
      end else if (kind < 9) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_item(rand_cmd(), $urandom_range(0, (1 << CHAN_W) - 1),
                   $urandom_range(0, (1 << FIELD_W) - 1), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, CH - 1);
        for (int c = 0; c < len; c++)
          add_item(CMD_SAMPLE, c, pick_sample(c), (c == len - 1) && $urandom_range(0, 1));
      end
    end

    // Wait until all has been sent and checked, then let the pipe settle
    do @(negedge clk);
    while (stim_q.size() != 0 || in_if.valid || avg_expected_q.size() != 0);
    repeat (TAIL_CYC) @(negedge clk);

    if (avg_expected_q.size() != 0)
      note_error("results still missing, count", 0, avg_expected_q.size());

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
